FILE: rtl/core/kal_pkg.sv
// ----------------------------------------------------------------------------
// kal_pkg: shared types and constants of the two sensor scalar kalman filter
// register indexes, update kinds, sequencer states and datapath widths
// ----------------------------------------------------------------------------
package kal_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_AREA       = 3'd0;
    localparam logic [2:0] CFG_TARE       = 3'd1;
    localparam logic [2:0] CFG_PROC_NOISE = 3'd2;
    localparam logic [2:0] CFG_VIS_NOISE  = 3'd3;
    localparam logic [2:0] CFG_SCL_NOISE  = 3'd4;
    localparam logic [2:0] CFG_MAX_AGE    = 3'd5;

    // update kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_VISION = 2'd1;
    localparam logic [1:0] KIND_SCALE  = 2'd2;
    localparam logic [1:0] KIND_BOTH   = 2'd3;

    // datapath widths
    localparam int GAIN_BITS = 30;
    localparam int MUL_W     = 33;
    localparam int DVD_W     = 64;
    localparam int DVS_W     = 33;

    // height in um to volume: divide by one thousand with rounding
    localparam logic [63:0] UM_PER_MM  = 64'd1000;
    localparam logic [63:0] UM_ROUND   = 64'd500;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZV_MUL,
        ST_ZV_MWAIT,
        ST_ZV_DIV,
        ST_ZV_DWAIT,
        ST_PROC,
        ST_K_DIV,
        ST_K_DWAIT,
        ST_D_MUL,
        ST_D_MWAIT,
        ST_X_UPD,
        ST_S_MUL,
        ST_S_MWAIT,
        ST_S_DIV,
        ST_S_DWAIT,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/core/kal_mul.sv
// ----------------------------------------------------------------------------
// kal_mul: bit-serial shift-add multiplier
// one multiplier bit per cycle, unsigned operands, full width product
// ----------------------------------------------------------------------------
module kal_mul
    import kal_pkg::*;
#(
    parameter int W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [2*W-1:0] o_product
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_a;
    logic [2*W-1:0]   r_p;
    logic [W:0]       w_sum;

    // add the multiplicand into the upper half when the low bit is set
    assign w_sum = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

FILE: rtl/core/kal_div.sv
// ----------------------------------------------------------------------------
// kal_div: restoring serial divider
// one quotient bit per cycle, unsigned, quotient over the whole dividend
// ----------------------------------------------------------------------------
module kal_div
    import kal_pkg::*;
#(
    parameter int DW = 64,
    parameter int SW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_q;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_dvs;
    logic [SW:0]      w_trial;
    logic             w_ge;
    logic [SW:0]      w_diff;

    // trial subtract of the divisor from the shifted remainder
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/core/two_sensor_scalar_kalman.sv
// ----------------------------------------------------------------------------
// two_sensor_scalar_kalman: scalar kalman filter fusing vision and scale
// one filter tick per input transaction, one result transaction per tick
// ----------------------------------------------------------------------------
// Each tick converts the vision height to a volume, removes the tare from the
// scale mass, adds the process noise to the variance and runs a vision, scale,
// both or no measurement update depending on sample freshness. Multiplications
// and divisions use one 33-step shift-add multiplier and one 64-step restoring
// divider: the vision volume needs one of each, a measurement update two of
// each, and an output stall holds the tick in the output state. A new tick is
// taken only in the idle state; a finished result may still be waiting on the
// output when the next tick is accepted.
module two_sensor_scalar_kalman
    import kal_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vision_height_um[17:0], vision_age_ms[27:18], scale_mass[59:28],
    // scale_age_ms[69:60], zero pad[71:70]
    input  logic [71:0] s_axis_tdata,
    // vision_new[0], scale_new[1]
    input  logic [1:0]  s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // volume_estimate[31:0], covariance_estimate[63:32]
    output logic [63:0] m_axis_tdata,
    // update_kind[1:0]
    output logic [1:0]  m_axis_tuser
);

    localparam logic [31:0] VAR_RESET = 32'd10 << FRAC_BITS;

    t_state r_state, n_state;

    // configuration registers
    logic [23:0]        r_area;
    logic signed [31:0] r_tare;
    logic [31:0]        r_pnoise;
    logic [31:0]        r_vnoise;
    logic [31:0]        r_snoise;
    logic [9:0]         r_max_age;

    // filter state
    logic signed [31:0] r_x;
    logic [31:0]        r_var;

    // per tick working registers
    logic [17:0]        r_height;
    logic               r_v_ok;
    logic               r_s_ok;
    logic signed [31:0] r_zs;
    logic signed [31:0] r_zv;
    logic               r_pass;
    logic [1:0]         r_kind;
    logic [32:0]        r_d;
    logic               r_neg;
    logic [32:0]        r_mag;
    logic [30:0]        r_k;
    logic [33:0]        r_delta;
    logic [63:0]        r_prod;

    // output register
    logic               r_ovalid;
    logic [63:0]        r_odata;
    logic [1:0]         r_okind;

    // unit handshakes
    logic               w_mul_start, w_div_start;
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_mul_p;
    logic               w_mul_done;
    logic [DVD_W-1:0]   w_dvd;
    logic [DVS_W-1:0]   w_dvs;
    logic [DVD_W-1:0]   w_div_q;
    logic               w_div_done;

    logic               w_accept;
    logic               w_v_ok_in, w_s_ok_in;
    logic signed [32:0] w_zs_full;
    logic signed [31:0] w_zs_sat;
    logic [31:0]        w_r;
    logic signed [31:0] w_z;
    logic [32:0]        w_d;
    logic               w_d_zero;
    logic signed [32:0] w_innov;
    logic [32:0]        w_var_sum;
    logic [63:0]        w_delta_rnd;
    logic signed [34:0] w_xn;
    logic               w_more;
    logic               w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;

    // input freshness and scale volume
    assign w_v_ok_in = s_axis_tuser[0] && (s_axis_tdata[27:18] <= r_max_age);
    assign w_s_ok_in = s_axis_tuser[1] && (s_axis_tdata[69:60] <= r_max_age);
    assign w_zs_full = {s_axis_tdata[59], s_axis_tdata[59:28]} - {r_tare[31], r_tare};
    assign w_zs_sat  = (w_zs_full[32] != w_zs_full[31]) ?
                       (w_zs_full[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) :
                       w_zs_full[31:0];

    // current measurement and noise
    assign w_r      = r_pass ? r_snoise : r_vnoise;
    assign w_z      = r_pass ? r_zs : r_zv;
    assign w_d      = {1'b0, r_var} + {1'b0, w_r};
    assign w_d_zero = (w_d == 33'd0);
    assign w_innov  = {w_z[31], w_z} - {r_x[31], r_x};
    assign w_more   = !r_pass && r_s_ok;

    assign w_var_sum   = {1'b0, r_var} + {1'b0, r_pnoise};
    assign w_delta_rnd = w_mul_p[63:0] + (64'd1 << (GAIN_BITS - 1));
    assign w_xn        = r_neg ? ({{3{r_x[31]}}, r_x} - {1'b0, r_delta}) :
                                 ({{3{r_x[31]}}, r_x} + {1'b0, r_delta});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_accept) n_state = w_v_ok_in ? ST_ZV_MUL : ST_PROC;
            ST_ZV_MUL:   n_state = ST_ZV_MWAIT;
            ST_ZV_MWAIT: if (w_mul_done) n_state = ST_ZV_DIV;
            ST_ZV_DIV:   n_state = ST_ZV_DWAIT;
            ST_ZV_DWAIT: if (w_div_done) n_state = ST_PROC;
            ST_PROC:     n_state = (r_v_ok || r_s_ok) ? ST_K_DIV : ST_OUT;
            ST_K_DIV: begin
                if (!w_d_zero) n_state = ST_K_DWAIT;
                else n_state = w_more ? ST_K_DIV : ST_OUT;
            end
            ST_K_DWAIT:  if (w_div_done) n_state = ST_D_MUL;
            ST_D_MUL:    n_state = ST_D_MWAIT;
            ST_D_MWAIT:  if (w_mul_done) n_state = ST_X_UPD;
            ST_X_UPD:    n_state = ST_S_MUL;
            ST_S_MUL:    n_state = ST_S_MWAIT;
            ST_S_MWAIT:  if (w_mul_done) n_state = ST_S_DIV;
            ST_S_DIV:    n_state = ST_S_DWAIT;
            ST_S_DWAIT:  if (w_div_done) n_state = w_more ? ST_K_DIV : ST_OUT;
            ST_OUT:      if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // state outputs: unit starts and operand selection
    always_comb begin
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_div_start   = 1'b0;
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_dvd         = '0;
        w_dvs         = '0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_ZV_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = {9'd0, r_area};
                w_mul_b     = {15'd0, r_height};
            end
            ST_ZV_DIV: begin
                w_div_start = 1'b1;
                w_dvd       = r_prod + UM_ROUND;
                w_dvs       = UM_PER_MM[DVS_W-1:0];
            end
            ST_K_DIV: begin
                w_div_start = !w_d_zero;
                w_dvd       = {2'd0, r_var, 30'd0} + {32'd0, w_d[32:1]};
                w_dvs       = w_d;
            end
            ST_D_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_mag;
                w_mul_b     = {2'd0, r_k};
            end
            ST_S_MUL: begin
                w_mul_start = 1'b1;
                w_mul_a     = {1'b0, r_var};
                w_mul_b     = {1'b0, w_r};
            end
            ST_S_DIV: begin
                w_div_start = 1'b1;
                w_dvd       = r_prod + {32'd0, r_d[32:1]};
                w_dvs       = r_d;
            end
            default: ;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_area    <= 24'd347079;
            r_tare    <= '0;
            r_pnoise  <= 32'd1311;
            r_vnoise  <= 32'd983040;
            r_snoise  <= 32'd98304;
            r_max_age <= 10'd200;
            r_x       <= '0;
            r_var     <= VAR_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_AREA:       r_area    <= i_cfg_data[23:0];
                    CFG_TARE:       r_tare    <= i_cfg_data;
                    CFG_PROC_NOISE: r_pnoise  <= i_cfg_data;
                    CFG_VIS_NOISE:  r_vnoise  <= i_cfg_data;
                    CFG_SCL_NOISE:  r_snoise  <= i_cfg_data;
                    CFG_MAX_AGE:    r_max_age <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (r_state == ST_PROC) begin
                r_var <= w_var_sum[32] ? 32'hFFFF_FFFF : w_var_sum[31:0];
            end
            if (r_state == ST_X_UPD) begin
                if (w_xn[34:31] != {4{w_xn[34]}}) begin
                    r_x <= w_xn[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_x <= w_xn[31:0];
                end
            end
            if (r_state == ST_S_DWAIT && w_div_done) begin
                r_var <= w_div_q[31:0];
            end
            // result register
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // per tick datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_height <= s_axis_tdata[17:0];
            r_v_ok   <= w_v_ok_in;
            r_s_ok   <= w_s_ok_in;
            r_zs     <= w_zs_sat;
        end
        if ((r_state == ST_ZV_MWAIT || r_state == ST_S_MWAIT) && w_mul_done) begin
            r_prod <= w_mul_p[63:0];
        end
        if (r_state == ST_ZV_DWAIT && w_div_done) begin
            r_zv <= (w_div_q[63:31] != 33'd0) ? 32'sh7FFF_FFFF : w_div_q[31:0];
        end
        if (r_state == ST_PROC) begin
            r_pass <= !r_v_ok;
            r_kind <= (r_v_ok && r_s_ok) ? KIND_BOTH :
                      r_v_ok ? KIND_VISION :
                      r_s_ok ? KIND_SCALE : KIND_NONE;
        end
        if (r_state == ST_K_DIV) begin
            r_d   <= w_d;
            r_neg <= w_innov[32];
            r_mag <= w_innov[32] ? 33'(-w_innov) : w_innov;
            if (w_d_zero && w_more) r_pass <= 1'b1;
        end
        if (r_state == ST_K_DWAIT && w_div_done) begin
            r_k <= w_div_q[30:0];
        end
        if (r_state == ST_D_MWAIT && w_mul_done) begin
            r_delta <= w_delta_rnd[63:GAIN_BITS];
        end
        if (r_state == ST_S_DWAIT && w_div_done && w_more) begin
            r_pass <= 1'b1;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_odata <= {r_var, r_x};
            r_okind <= r_kind;
        end
    end

    kal_mul #(.W(MUL_W)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    kal_div #(.DW(DVD_W), .SW(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;

`ifndef SYNTHESIS
    // multiplier finishes only while the sequencer waits for it
    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_ZV_MWAIT || r_state == ST_D_MWAIT ||
                        r_state == ST_S_MWAIT))
        else $error("multiplier done outside a wait state");

    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_ZV_DWAIT || r_state == ST_K_DWAIT ||
                        r_state == ST_S_DWAIT))
        else $error("divider done outside a wait state");

    // a new result only appears after the output state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_OUT)
        else $error("result raised outside the output state");

    // no update runs on a tick with no fresh sample
    a_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_K_DIV) |-> (r_v_ok || r_s_ok))
        else $error("measurement update without a fresh sample");
`endif

endmodule

FILE: tb/sv/two_sensor_scalar_kalman_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_sensor_scalar_kalman_test: self-checking bench of the kalman filter
// ----------------------------------------------------------------------------
// Ticks are queued by a stimulus process, sent by a clocked driver with
// random gaps and checked by a clocked monitor against a local predictor of
// the fixed point filter. Registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
module two_sensor_scalar_kalman_test;
    import kal_pkg::*;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic        v_new;
        logic [17:0] height;
        logic [9:0]  v_age;
        logic        s_new;
        logic [31:0] mass;
        logic [9:0]  s_age;
    } tick_t;

    typedef struct packed {
        logic [31:0] vol;
        logic [31:0] cov;
        logic [1:0]  kind;
    } est_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    two_sensor_scalar_kalman #(.FRAC_BITS(FRAC)) dut (.*);

    // predictor state and configuration
    logic [23:0] area;
    logic signed [31:0] tare;
    logic [31:0] q_noise, r_vis, r_scl;
    logic [9:0]  age_max;
    logic signed [31:0] vol_est;
    logic [31:0] var_est;

    tick_t pending_ticks[$];
    est_t  expected_estimates[$];
    int    errors = 0;
    int    gap_left = 0;
    int    stall_left = 0;
    bit    hold_off = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] sat_s32(logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'h7fffffff;
        if (v < -66'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic void kalman_correct(input logic signed [31:0] z,
                                           input logic [31:0] r);
        logic [63:0] s, d, k, mag, dlt;
        logic signed [65:0] innov;
        logic [127:0] prod;
        s = {32'd0, var_est};
        d = s + {32'd0, r};
        if (d == 0) return;
        k = ((s << GAIN_BITS) + (d >> 1)) / d;
        innov = $signed({{34{z[31]}}, z}) - $signed({{34{vol_est[31]}}, vol_est});
        mag = innov < 0 ? 64'(-innov) : 64'(innov);
        prod = {64'd0, mag} * {64'd0, k} + (128'd1 << (GAIN_BITS - 1));
        dlt = 64'(prod >> GAIN_BITS);
        if (innov < 0)
            vol_est = sat_s32($signed({{34{vol_est[31]}}, vol_est}) - $signed({2'b0, dlt}));
        else
            vol_est = sat_s32($signed({{34{vol_est[31]}}, vol_est}) + $signed({2'b0, dlt}));
        var_est = 32'((s * {32'd0, r} + (d >> 1)) / d);
    endfunction

    function automatic est_t filter_tick(tick_t t);
        est_t e;
        logic v_ok, s_ok;
        logic [63:0] vq, sum;
        logic signed [31:0] zv, zs;
        v_ok = t.v_new && t.v_age <= age_max;
        s_ok = t.s_new && t.s_age <= age_max;
        vq = ({40'd0, area} * {46'd0, t.height} + 64'd500) / 64'd1000;
        zv = vq > 64'h7fffffff ? 32'h7fffffff : vq[31:0];
        zs = sat_s32($signed({{34{t.mass[31]}}, t.mass}) - $signed({{34{tare[31]}}, tare}));
        sum = {32'd0, var_est} + {32'd0, q_noise};
        var_est = sum > 64'hffffffff ? 32'hffffffff : sum[31:0];
        if (v_ok && s_ok) begin
            kalman_correct(zv, r_vis);
            kalman_correct(zs, r_scl);
            e.kind = KIND_BOTH;
        end else if (v_ok) begin
            kalman_correct(zv, r_vis);
            e.kind = KIND_VISION;
        end else if (s_ok) begin
            kalman_correct(zs, r_scl);
            e.kind = KIND_SCALE;
        end else begin
            e.kind = KIND_NONE;
        end
        e.vol = vol_est;
        e.cov = var_est;
        return e;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return $urandom_range(0, 4);
    endfunction

    // driver: one tick transaction at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold until accepted
        end else begin
            if (s_axis_tvalid)
                expected_estimates.push_back(filter_tick(tick_t'({s_axis_tuser[0],
                    s_axis_tdata[17:0], s_axis_tdata[27:18], s_axis_tuser[1],
                    s_axis_tdata[59:28], s_axis_tdata[69:60]})));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0 && !hold_off) begin
                tick_t t;
                t = pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {2'b0, t.s_age, t.mass, t.v_age, t.height};
                s_axis_tuser <= {t.s_new, t.v_new};
                gap_left <= rand_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure and field checks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t unexpected result: actual %h/%h", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    est_t e;
                    e = expected_estimates.pop_front();
                    if (m_axis_tdata[31:0] !== e.vol) begin
                        $display("%0t volume: expected %h actual %h", $time,
                                 e.vol, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== e.cov) begin
                        $display("%0t covariance: expected %h actual %h", $time,
                                 e.cov, m_axis_tdata[63:32]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.kind) begin
                        $display("%0t kind: expected %0d actual %0d", $time,
                                 e.kind, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left <= rand_gap();
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AREA:       area = val[23:0];
            CFG_TARE:       tare = val;
            CFG_PROC_NOISE: q_noise = val;
            CFG_VIS_NOISE:  r_vis = val;
            CFG_SCL_NOISE:  r_scl = val;
            CFG_MAX_AGE:    age_max = val[9:0];
            default: ;
        endcase
    endtask

    // wait until every queued tick has been checked
    task automatic drain();
        while (pending_ticks.size() > 0 || s_axis_tvalid || expected_estimates.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic tick_t rand_tick();
        tick_t t;
        t.v_new = $urandom_range(0, 3) != 0;
        t.s_new = $urandom_range(0, 3) != 0;
        t.height = $urandom_range(0, 7) == 0 ? 18'($urandom) : 18'($urandom_range(0, 120000));
        t.v_age = $urandom_range(0, 5) == 0 ? 10'($urandom) : 10'($urandom_range(0, 250));
        t.s_age = $urandom_range(0, 5) == 0 ? 10'($urandom) : 10'($urandom_range(0, 250));
        t.mass = $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 1 << 26));
        return t;
    endfunction

    function automatic tick_t mk_tick(logic vn, logic [17:0] h, logic [9:0] va,
                                      logic sn, logic [31:0] m, logic [9:0] sa);
        return tick_t'({vn, h, va, sn, m, sa});
    endfunction

    // stimulus
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        area = 24'd347079;
        tare = 0;
        q_noise = 32'd1311;
        r_vis = 32'd983040;
        r_scl = 32'd98304;
        age_max = 10'd200;
        vol_est = 0;
        var_est = 32'd10 << FRAC;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, each kind and field extremes
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(mk_tick(1, 18'd50000, 10'd0, 0, 0, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 1, 32'd300 << 16, 10'd200));
        pending_ticks.push_back(mk_tick(1, 18'h3ffff, 10'd200, 1, 32'h7fffffff, 10'd0));
        pending_ticks.push_back(mk_tick(1, 18'd1000, 10'd201, 1, 32'h80000000, 10'd1023));
        pending_ticks.push_back(mk_tick(1, 0, 10'd1023, 1, 32'h80000000, 10'd5));
        pending_ticks.push_back(mk_tick(1, 18'h3ffff, 10'd0, 0, 32'hffffffff, 10'd0));
        drain();
        // extremes: big area, tare saturation, zero noises
        cfg_write(CFG_AREA, 32'hffffff);
        cfg_write(CFG_TARE, 32'h7fffffff);
        cfg_write(CFG_PROC_NOISE, 32'hffffffff);
        cfg_write(CFG_VIS_NOISE, 32'd0);
        cfg_write(CFG_SCL_NOISE, 32'd0);
        cfg_write(CFG_MAX_AGE, 32'd1023);
        pending_ticks.push_back(mk_tick(1, 18'h3ffff, 10'd1023, 1, 32'h80000000, 10'd1023));
        pending_ticks.push_back(mk_tick(0, 0, 0, 1, 32'h80000000, 10'd0));
        pending_ticks.push_back(mk_tick(1, 18'd7, 10'd3, 0, 0, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0));
        drain();
        // zero process noise with zero sensor noise gives a zero denominator
        cfg_write(CFG_PROC_NOISE, 32'd0);
        cfg_write(CFG_TARE, 32'h80000000);
        cfg_write(CFG_MAX_AGE, 32'd0);
        pending_ticks.push_back(mk_tick(1, 18'd100, 10'd0, 1, 32'h7fffffff, 10'd0));
        pending_ticks.push_back(mk_tick(1, 18'd100, 10'd1, 1, 32'd5, 10'd0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 1, 32'd0, 10'd0));
        drain();
        cfg_write(CFG_VIS_NOISE, 32'hffffffff);
        cfg_write(CFG_SCL_NOISE, 32'hffffffff);
        cfg_write(CFG_AREA, 32'd0);
        pending_ticks.push_back(mk_tick(1, 18'h3ffff, 10'd0, 1, 32'd1234, 10'd0));
        pending_ticks.push_back(mk_tick(1, 18'h3ffff, 10'd0, 0, 32'd1234, 10'd0));
        drain();

        // random phases under several settings
        for (int ph = 0; ph < 5; ph++) begin
            cfg_write(CFG_AREA, ph == 4 ? 32'hffffff : 32'($urandom_range(1000, 700000)));
            cfg_write(CFG_TARE, ph == 3 ? $urandom : 32'($urandom_range(0, 1 << 22)));
            cfg_write(CFG_PROC_NOISE, ph == 4 ? $urandom : 32'($urandom_range(0, 70000)));
            cfg_write(CFG_VIS_NOISE, ph == 2 ? $urandom : 32'($urandom_range(1, 2000000)));
            cfg_write(CFG_SCL_NOISE, ph == 2 ? $urandom : 32'($urandom_range(1, 500000)));
            cfg_write(CFG_MAX_AGE, 32'($urandom_range(100, 1023)));
            for (int n = 0; n < 200; n++)
                pending_ticks.push_back(rand_tick());
            if (ph == 1) begin
                // stop the sender until all results are back
                while (pending_ticks.size() > 100) @(posedge i_clk);
                hold_off = 1;
                while (s_axis_tvalid || expected_estimates.size() > 0) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #(64'd12 * 64'd3000000);
        $display("simulation failed");
        $finish;
    end

endmodule
